/* rtl/orth_pkg.sv */
// Shared types, widths and rounding helper for the 3x3 orthonormalizer.
package orth_pkg;

  localparam int FRAC_OUT = 30;   // fraction bits of unit entries
  localparam int LIM_W    = 17;
  localparam int V_W      = 33;   // residual component, signed
  localparam int Q_W      = 32;   // unit entry, signed
  localparam int RS_W     = 68;   // working width of the rounding shift
  localparam int STEPS    = 2;    // root or quotient bits resolved per stage

  localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(1);

  localparam logic signed [RS_W-1:0] DOT_MAX   = RS_W'(64'sd4294967296);
  localparam logic signed [RS_W-1:0] RESID_MAX = RS_W'(64'sd4294967295);

  typedef struct packed {
    logic signed [31:0] m_c0_r0;
    logic signed [31:0] m_c0_r1;
    logic signed [31:0] m_c0_r2;
    logic signed [31:0] m_c1_r0;
    logic signed [31:0] m_c1_r1;
    logic signed [31:0] m_c1_r2;
    logic signed [31:0] m_c2_r0;
    logic signed [31:0] m_c2_r1;
    logic signed [31:0] m_c2_r2;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] q_c0_r0;
    logic signed [31:0] q_c0_r1;
    logic signed [31:0] q_c0_r2;
    logic signed [31:0] q_c1_r0;
    logic signed [31:0] q_c1_r1;
    logic signed [31:0] q_c1_r2;
    logic signed [31:0] q_c2_r0;
    logic signed [31:0] q_c2_r1;
    logic signed [31:0] q_c2_r2;
  } out_item_t;

  // Shift right by FRAC_OUT, rounding half away from zero.
  function automatic logic signed [RS_W-1:0] rnd_shift(input logic signed [RS_W-1:0] x);
    logic [RS_W-1:0] m;
    logic [RS_W-1:0] r;
    m = x[RS_W-1] ? RS_W'(-x) : RS_W'(x);
    r = (m + (RS_W'(1) << (FRAC_OUT - 1))) >> FRAC_OUT;
    return x[RS_W-1] ? $signed(-r) : $signed(r);
  endfunction

endpackage

/* rtl/orth_unit.sv */
// Pipelined normalizer: squared length, digit-by-digit root, three restoring dividers.
module orth_unit #(
  parameter int SB_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  logic [2:0][orth_pkg::V_W-1:0] in_v,
  input  logic [SB_W-1:0]               in_sb,
  input  logic [orth_pkg::LIM_W-1:0]    limit,
  output logic                          out_vld,
  output logic [2:0][orth_pkg::Q_W-1:0] out_q,
  output logic                          out_bad,
  output logic [SB_W-1:0]               out_sb
);
  import orth_pkg::*;

  localparam int RT_W  = 32;
  localparam int NS    = RT_W / STEPS;
  localparam int S_W   = 2 * RT_W;
  localparam int REM_W = RT_W + 4;
  localparam int N_W   = 1 + RT_W + FRAC_OUT;
  localparam logic [RT_W-1:0] UNIT = RT_W'(1) << FRAC_OUT;

  // magnitudes of the incoming column
  logic [RT_W-1:0] mag_in [3];
  logic [2:0]      neg_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = in_v[i][V_W-1];
      mag_in[i] = neg_in[i] ? RT_W'(-in_v[i]) : RT_W'(in_v[i]);
    end
  end

  // stage A: squares
  logic            a_vld_r;
  logic [S_W-1:0]  a_sq_r  [3];
  logic [RT_W-1:0] a_mag_r [3];
  logic [2:0]      a_neg_r;
  logic [SB_W-1:0] a_sb_r;
  logic [S_W-1:0]  sq_nxt  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = mag_in[i] * mag_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sq_r  <= sq_nxt;
      a_mag_r <= mag_in;
      a_neg_r <= neg_in;
      a_sb_r  <= in_sb;
    end
  end

  // root pipeline; entry 0 holds the saturated sum of squares
  logic            sr_vld_r  [0:NS];
  logic [S_W-1:0]  sr_s_r    [0:NS];
  logic [REM_W-1:0] sr_rem_r [0:NS];
  logic [RT_W-1:0] sr_root_r [0:NS];
  logic [RT_W-1:0] sr_mag_r  [0:NS][3];
  logic [2:0]      sr_neg_r  [0:NS];
  logic [SB_W-1:0] sr_sb_r   [0:NS];
  logic [S_W+1:0]  sq_sum;

  assign sq_sum = (S_W+2)'(a_sq_r[0]) + (S_W+2)'(a_sq_r[1]) + (S_W+2)'(a_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sr_vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_s_r[0]    <= (|sq_sum[S_W+1:S_W]) ? '1 : sq_sum[S_W-1:0];
      sr_rem_r[0]  <= '0;
      sr_root_r[0] <= '0;
      sr_mag_r[0]  <= a_mag_r;
      sr_neg_r[0]  <= a_neg_r;
      sr_sb_r[0]   <= a_sb_r;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_sqrt
    logic [S_W-1:0]   s_c;
    logic [REM_W-1:0] rem_c;
    logic [REM_W-1:0] trial;
    logic [RT_W-1:0]  root_c;

    always_comb begin
      s_c    = sr_s_r[k-1];
      rem_c  = sr_rem_r[k-1];
      root_c = sr_root_r[k-1];
      trial  = '0;
      for (int j = 0; j < STEPS; j++) begin
        rem_c = {rem_c[REM_W-3:0], s_c[S_W-1 -: 2]};
        trial = {{(REM_W-RT_W-2){1'b0}}, root_c, 2'b01};
        if (rem_c >= trial) begin
          rem_c  = rem_c - trial;
          root_c = {root_c[RT_W-2:0], 1'b1};
        end else begin
          root_c = {root_c[RT_W-2:0], 1'b0};
        end
        s_c = s_c << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_vld_r[k] <= 1'b0;
      end else if (adv) begin
        sr_vld_r[k] <= sr_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_s_r[k]    <= s_c;
        sr_rem_r[k]  <= rem_c;
        sr_root_r[k] <= root_c;
        sr_mag_r[k]  <= sr_mag_r[k-1];
        sr_neg_r[k]  <= sr_neg_r[k-1];
        sr_sb_r[k]   <= sr_sb_r[k-1];
      end
    end
  end

  // divider pipeline; entry 0 sets up the rounded numerators
  logic            dv_vld_r [0:NS];
  logic [RT_W:0]   dv_rem_r [0:NS][3];
  logic [RT_W-1:0] dv_n_r   [0:NS][3];
  logic [RT_W-1:0] dv_quo_r [0:NS][3];
  logic [RT_W-1:0] dv_len_r [0:NS];
  logic            dv_bad_r [0:NS];
  logic [2:0]      dv_neg_r [0:NS];
  logic [SB_W-1:0] dv_sb_r  [0:NS];
  logic [RT_W-1:0] len_c;
  logic [N_W-1:0]  num_c [3];

  assign len_c = sr_root_r[NS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = N_W'({sr_mag_r[NS][i], {FRAC_OUT{1'b0}}}) + N_W'(len_c >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= sr_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= (RT_W+1)'(num_c[i][N_W-1:RT_W]);
        dv_n_r[0][i]   <= num_c[i][RT_W-1:0];
        dv_quo_r[0][i] <= '0;
      end
      dv_len_r[0] <= len_c;
      dv_bad_r[0] <= len_c <= RT_W'(limit);
      dv_neg_r[0] <= sr_neg_r[NS];
      dv_sb_r[0]  <= sr_sb_r[NS];
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_div
    logic [RT_W:0]   rem_c [3];
    logic [RT_W-1:0] n_c   [3];
    logic [RT_W-1:0] quo_c [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_c[i] = dv_rem_r[k-1][i];
        n_c[i]   = dv_n_r[k-1][i];
        quo_c[i] = dv_quo_r[k-1][i];
        for (int j = 0; j < STEPS; j++) begin
          rem_c[i] = {rem_c[i][RT_W-1:0], n_c[i][RT_W-1]};
          if (rem_c[i] >= {1'b0, dv_len_r[k-1]}) begin
            rem_c[i] = rem_c[i] - {1'b0, dv_len_r[k-1]};
            quo_c[i] = {quo_c[i][RT_W-2:0], 1'b1};
          end else begin
            quo_c[i] = {quo_c[i][RT_W-2:0], 1'b0};
          end
          n_c[i] = n_c[i] << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k] <= rem_c;
        dv_n_r[k]   <= n_c;
        dv_quo_r[k] <= quo_c;
        dv_len_r[k] <= dv_len_r[k-1];
        dv_bad_r[k] <= dv_bad_r[k-1];
        dv_neg_r[k] <= dv_neg_r[k-1];
        dv_sb_r[k]  <= dv_sb_r[k-1];
      end
    end
  end

  // output: clamp to one and restore the sign
  logic                    o_vld_r;
  logic [2:0][Q_W-1:0]     o_q_r;
  logic                    o_bad_r;
  logic [SB_W-1:0]         o_sb_r;
  logic [2:0][Q_W-1:0]     q_nxt;
  logic [RT_W-1:0]         qm;

  always_comb begin
    qm = '0;
    for (int i = 0; i < 3; i++) begin
      qm       = (dv_quo_r[NS][i] > UNIT) ? UNIT : dv_quo_r[NS][i];
      q_nxt[i] = dv_neg_r[NS][i] ? Q_W'(-qm) : Q_W'(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= dv_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_q_r   <= q_nxt;
      o_bad_r <= dv_bad_r[NS];
      o_sb_r  <= dv_sb_r[NS];
    end
  end

  assign out_vld = o_vld_r;
  assign out_q   = o_q_r;
  assign out_bad = o_bad_r;
  assign out_sb  = o_sb_r;

endmodule

/* rtl/orth_strip.sv */
// Pipelined removal of a residual's projection on one unit column.
module orth_strip #(
  parameter int SB_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  logic [2:0][orth_pkg::Q_W-1:0] in_q,
  input  logic [2:0][orth_pkg::V_W-1:0] in_v,
  input  logic [SB_W-1:0]               in_sb,
  output logic                          out_vld,
  output logic [2:0][orth_pkg::V_W-1:0] out_v,
  output logic [SB_W-1:0]               out_sb
);
  import orth_pkg::*;

  localparam int P_W  = Q_W + V_W;
  localparam int D_W  = P_W + 2;
  localparam int DQ_W = 34;
  localparam int PR_W = Q_W + DQ_W;

  logic [4:0]              vld_r;
  logic [SB_W-1:0]         sb_r [5];

  // stage 0: products of the dot
  logic signed [P_W-1:0]   s0_p_r [3];
  logic signed [Q_W-1:0]   s0_q_r [3];
  logic signed [V_W-1:0]   s0_v_r [3];
  // stage 1: dot sum
  logic signed [D_W-1:0]   s1_d_r;
  logic signed [Q_W-1:0]   s1_q_r [3];
  logic signed [V_W-1:0]   s1_v_r [3];
  // stage 2: rounded and clamped dot
  logic signed [DQ_W-1:0]  s2_dq_r;
  logic signed [Q_W-1:0]   s2_q_r [3];
  logic signed [V_W-1:0]   s2_v_r [3];
  // stage 3: projection products
  logic signed [PR_W-1:0]  s3_pr_r [3];
  logic signed [V_W-1:0]   s3_v_r  [3];
  // stage 4: residual
  logic [2:0][V_W-1:0]     s4_v_r;

  logic signed [RS_W-1:0]  dq_rnd;
  logic signed [RS_W-1:0]  dq_cl;
  logic signed [RS_W-1:0]  res_c [3];
  logic [2:0][V_W-1:0]     res_nxt;

  always_comb begin
    dq_rnd = rnd_shift(RS_W'(s1_d_r));
    if (dq_rnd > DOT_MAX) begin
      dq_cl = DOT_MAX;
    end else if (dq_rnd < -DOT_MAX) begin
      dq_cl = -DOT_MAX;
    end else begin
      dq_cl = dq_rnd;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_c[i] = RS_W'(s3_v_r[i]) - rnd_shift(RS_W'(s3_pr_r[i]));
      if (res_c[i] > RESID_MAX) begin
        res_c[i] = RESID_MAX;
      end else if (res_c[i] < -RESID_MAX) begin
        res_c[i] = -RESID_MAX;
      end
      res_nxt[i] = V_W'(res_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s0_p_r[i]  <= $signed(in_q[i]) * $signed(in_v[i]);
        s0_q_r[i]  <= $signed(in_q[i]);
        s0_v_r[i]  <= $signed(in_v[i]);
        s1_q_r[i]  <= s0_q_r[i];
        s1_v_r[i]  <= s0_v_r[i];
        s2_q_r[i]  <= s1_q_r[i];
        s2_v_r[i]  <= s1_v_r[i];
        s3_pr_r[i] <= s2_q_r[i] * s2_dq_r;
        s3_v_r[i]  <= s2_v_r[i];
      end
      s1_d_r  <= D_W'(s0_p_r[0]) + D_W'(s0_p_r[1]) + D_W'(s0_p_r[2]);
      s2_dq_r <= DQ_W'(dq_cl);
      s4_v_r  <= res_nxt;
      sb_r[0] <= in_sb;
      for (int k = 1; k < 5; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign out_vld = vld_r[4];
  assign out_v   = s4_v_r;
  assign out_sb  = sb_r[4];

endmodule

/* rtl/orth_det.sv */
// Determinant sign check, column 2 flip and result assembly.
module orth_det (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  logic [2:0][orth_pkg::Q_W-1:0] q0,
  input  logic [2:0][orth_pkg::Q_W-1:0] q1,
  input  logic [2:0][orth_pkg::Q_W-1:0] q2,
  input  logic                          in_bad,
  output logic                          out_vld,
  output orth_pkg::out_item_t           out_item
);
  import orth_pkg::*;

  localparam int M_W = 2 * Q_W;
  localparam int X_W = Q_W + 1;
  localparam int T_W = Q_W + X_W;
  localparam int S_W = T_W + 2;

  logic [3:0]             vld_r;
  logic [2:0][Q_W-1:0]    q0_r [3];
  logic [2:0][Q_W-1:0]    q1_r [3];
  logic [2:0][Q_W-1:0]    q2_r [3];
  logic [2:0]             bad_r;

  logic signed [M_W-1:0]  d0_a_r [3];
  logic signed [M_W-1:0]  d0_b_r [3];
  logic signed [X_W-1:0]  d1_x_r [3];
  logic signed [T_W-1:0]  d2_t_r [3];
  out_item_t              d3_item_r;

  logic signed [X_W-1:0]  x_nxt [3];
  logic signed [S_W-1:0]  det_c;
  logic [2:0][Q_W-1:0]    q2_fix;
  out_item_t              item_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_nxt[i] = X_W'(rnd_shift(RS_W'((M_W+1)'(d0_a_r[i]) - (M_W+1)'(d0_b_r[i]))));
    end
  end

  always_comb begin
    det_c = S_W'(d2_t_r[0]) + S_W'(d2_t_r[1]) + S_W'(d2_t_r[2]);
    for (int i = 0; i < 3; i++) begin
      q2_fix[i] = det_c[S_W-1] ? Q_W'(-q2_r[2][i]) : q2_r[2][i];
    end
    item_nxt.ok      = !bad_r[2];
    item_nxt.q_c0_r0 = bad_r[2] ? '0 : q0_r[2][0];
    item_nxt.q_c0_r1 = bad_r[2] ? '0 : q0_r[2][1];
    item_nxt.q_c0_r2 = bad_r[2] ? '0 : q0_r[2][2];
    item_nxt.q_c1_r0 = bad_r[2] ? '0 : q1_r[2][0];
    item_nxt.q_c1_r1 = bad_r[2] ? '0 : q1_r[2][1];
    item_nxt.q_c1_r2 = bad_r[2] ? '0 : q1_r[2][2];
    item_nxt.q_c2_r0 = bad_r[2] ? '0 : q2_fix[0];
    item_nxt.q_c2_r1 = bad_r[2] ? '0 : q2_fix[1];
    item_nxt.q_c2_r2 = bad_r[2] ? '0 : q2_fix[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // cross product of columns 0 and 1
      d0_a_r[0] <= $signed(q0[1]) * $signed(q1[2]);
      d0_b_r[0] <= $signed(q0[2]) * $signed(q1[1]);
      d0_a_r[1] <= $signed(q0[2]) * $signed(q1[0]);
      d0_b_r[1] <= $signed(q0[0]) * $signed(q1[2]);
      d0_a_r[2] <= $signed(q0[0]) * $signed(q1[1]);
      d0_b_r[2] <= $signed(q0[1]) * $signed(q1[0]);
      for (int i = 0; i < 3; i++) begin
        d1_x_r[i] <= x_nxt[i];
        d2_t_r[i] <= $signed(q2_r[1][i]) * d1_x_r[i];
      end
      q0_r[0]   <= q0;
      q1_r[0]   <= q1;
      q2_r[0]   <= q2;
      bad_r[0]  <= in_bad;
      for (int k = 1; k < 3; k++) begin
        q0_r[k]  <= q0_r[k-1];
        q1_r[k]  <= q1_r[k-1];
        q2_r[k]  <= q2_r[k-1];
        bad_r[k] <= bad_r[k-1];
      end
      d3_item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_item = d3_item_r;

endmodule

/* rtl/orthonormalize_3x3_matrix.sv */
// Gram-Schmidt orthonormalizer for 3x3 Q16.16 matrices, Q1.30 unit columns out.
//
// One matrix enters per clock while in_stall is low and passes three normalizers
// (each a 16-stage root and 16-stage divider, two bits per stage), three 5-stage
// projection removers and a 4-stage determinant check. A result arriving while
// out_stall holds the output register is parked in a one-entry skid register;
// in_stall rises once it is full. The degenerate-length limit resets to 1; the
// user writes it on the cfg port only while no matrix is in flight (unchecked).
module orthonormalize_3x3_matrix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  orth_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output orth_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [orth_pkg::LIM_W-1:0]  cfg_data
);
  import orth_pkg::*;

  localparam int V3_W  = 3 * V_W;
  localparam int Q3_W  = 3 * Q_W;
  localparam int SB0_W = 2 * V3_W;
  localparam int SB1_W = Q3_W;
  localparam int SB2_W = 1;
  localparam int SB3_W = Q3_W + 1 + V3_W;
  localparam int SB4_W = 2 * Q3_W + 1;

  logic              adv;
  logic [LIM_W-1:0]  limit_r;
  logic              out_vld_r;
  logic              skid_vld_r;
  out_item_t         out_r;
  out_item_t         skid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // the whole pipeline holds while the skid register is full
  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;

  logic [2:0][V_W-1:0] col0, col1, col2;

  assign col0 = {V_W'(in_data.m_c0_r2), V_W'(in_data.m_c0_r1), V_W'(in_data.m_c0_r0)};
  assign col1 = {V_W'(in_data.m_c1_r2), V_W'(in_data.m_c1_r1), V_W'(in_data.m_c1_r0)};
  assign col2 = {V_W'(in_data.m_c2_r2), V_W'(in_data.m_c2_r1), V_W'(in_data.m_c2_r0)};

  // column 0
  logic                u0_vld;
  logic [2:0][Q_W-1:0] u0_q;
  logic                u0_bad;
  logic [SB0_W-1:0]    u0_sb;

  orth_unit #(.SB_W(SB0_W)) u_unit0 (
    .clk, .rst_n, .adv,
    .in_vld  (in_valid && !in_stall),
    .in_v    (col0),
    .in_sb   ({col1, col2}),
    .limit   (limit_r),
    .out_vld (u0_vld),
    .out_q   (u0_q),
    .out_bad (u0_bad),
    .out_sb  (u0_sb)
  );

  // take q0 out of columns 1 and 2 side by side
  logic                s1_vld, s2_vld;
  logic [2:0][V_W-1:0] s1_v, s2_v;
  logic [SB1_W-1:0]    s1_sb;
  logic [SB2_W-1:0]    s2_sb;

  orth_strip #(.SB_W(SB1_W)) u_strip1 (
    .clk, .rst_n, .adv,
    .in_vld  (u0_vld),
    .in_q    (u0_q),
    .in_v    (u0_sb[SB0_W-1:V3_W]),
    .in_sb   (u0_q),
    .out_vld (s1_vld),
    .out_v   (s1_v),
    .out_sb  (s1_sb)
  );

  orth_strip #(.SB_W(SB2_W)) u_strip2 (
    .clk, .rst_n, .adv,
    .in_vld  (u0_vld),
    .in_q    (u0_q),
    .in_v    (u0_sb[V3_W-1:0]),
    .in_sb   (u0_bad),
    .out_vld (s2_vld),
    .out_v   (s2_v),
    .out_sb  (s2_sb)
  );

  // column 1
  logic                u1_vld;
  logic [2:0][Q_W-1:0] u1_q;
  logic                u1_bad;
  logic [SB3_W-1:0]    u1_sb;

  orth_unit #(.SB_W(SB3_W)) u_unit1 (
    .clk, .rst_n, .adv,
    .in_vld  (s1_vld && s2_vld),
    .in_v    (s1_v),
    .in_sb   ({s1_sb, s2_sb, s2_v}),
    .limit   (limit_r),
    .out_vld (u1_vld),
    .out_q   (u1_q),
    .out_bad (u1_bad),
    .out_sb  (u1_sb)
  );

  // take q1 out of column 2
  logic                s3_vld;
  logic [2:0][V_W-1:0] s3_v;
  logic [SB4_W-1:0]    s3_sb;

  orth_strip #(.SB_W(SB4_W)) u_strip3 (
    .clk, .rst_n, .adv,
    .in_vld  (u1_vld),
    .in_q    (u1_q),
    .in_v    (u1_sb[V3_W-1:0]),
    .in_sb   ({u1_sb[SB3_W-1:V3_W+1], u1_q, u1_sb[V3_W] | u1_bad}),
    .out_vld (s3_vld),
    .out_v   (s3_v),
    .out_sb  (s3_sb)
  );

  // column 2
  logic                u2_vld;
  logic [2:0][Q_W-1:0] u2_q;
  logic                u2_bad;
  logic [SB4_W-1:0]    u2_sb;

  orth_unit #(.SB_W(SB4_W)) u_unit2 (
    .clk, .rst_n, .adv,
    .in_vld  (s3_vld),
    .in_v    (s3_v),
    .in_sb   (s3_sb),
    .limit   (limit_r),
    .out_vld (u2_vld),
    .out_q   (u2_q),
    .out_bad (u2_bad),
    .out_sb  (u2_sb)
  );

  logic      d_vld;
  out_item_t d_item;

  orth_det u_det (
    .clk, .rst_n, .adv,
    .in_vld   (u2_vld),
    .q0       (u2_sb[SB4_W-1:Q3_W+1]),
    .q1       (u2_sb[Q3_W:1]),
    .q2       (u2_q),
    .in_bad   (u2_sb[0] | u2_bad),
    .out_vld  (d_vld),
    .out_item (d_item)
  );

  // output register with one-entry skid
  logic leave;
  logic out_free;

  assign leave    = adv && d_vld;
  assign out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= leave;
      end
    end else if (leave) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_vld_r ? skid_r : d_item;
    end else if (leave) begin
      skid_r <= d_item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !out_stall |=> out_vld_r && !skid_vld_r)
    else $error("skid entry not moved after output transfer");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.ok |-> out_r.q_c0_r0 == '0 && out_r.q_c0_r1 == '0 &&
      out_r.q_c0_r2 == '0 && out_r.q_c1_r0 == '0 && out_r.q_c1_r1 == '0 &&
      out_r.q_c1_r2 == '0 && out_r.q_c2_r0 == '0 && out_r.q_c2_r1 == '0 &&
      out_r.q_c2_r2 == '0)
    else $error("degenerate result carries nonzero entries");

endmodule
